FILE: rtl/core/lpga_pkg.sv
`default_nettype none
package lpga_pkg;

  localparam int MAX_SLOTS     = 256;
  localparam int INITIAL_SLOTS = 4;
  localparam int KEY_BITS      = 32;

  localparam int ID_W   = 32;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int ORD_W  = 9;
  localparam int SIZE_W = 9;
  localparam int LOG_W  = $clog2(SLOT_W + 1);
  localparam int DEPTH  = 2 * MAX_SLOTS;
  localparam int INIT_LOG = $clog2(INITIAL_SLOTS);
  localparam int OUT_W  = 24;

  localparam logic [1:0] WR_CLR_INIT = 2'd0;
  localparam logic [1:0] WR_CLR_NEW  = 2'd1;
  localparam logic [1:0] WR_MOVE     = 2'd2;
  localparam logic [1:0] WR_INSERT   = 2'd3;

  typedef struct packed {
    logic             used;
    logic [ORD_W-1:0] order;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic       start;
    logic       rd_en;
    logic       rd_scan;
    logic       use_new;
    logic       pos_next;
    logic       i_inc;
    logic       i_zero;
    logic       mv_latch;
    logic       grow_end;
    logic       wr_en;
    logic [1:0] wr_kind;
    logic       set_hit;
    logic       set_full;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic used;
    logic match;
    logic probe_last;
    logic grow_ok;
    logic clr_last;
    logic scan_last;
    logic init_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/lpga_ctrl.sv
`default_nettype none
module lpga_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lpga_pkg::stat_t st,
  output lpga_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_GCLR = 4'd4;
  localparam logic [3:0] S_GRD  = 4'd5;
  localparam logic [3:0] S_GCHK = 4'd6;
  localparam logic [3:0] S_MRD  = 4'd7;
  localparam logic [3:0] S_MCHK = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = lpga_pkg::WR_CLR_INIT;
        cmd.i_inc   = 1'b1;
        if (st.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        priority if (!st.used) begin
          if (st.grow_ok) begin
            cmd.i_zero = 1'b1;
            state_next = S_GCLR;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_kind = lpga_pkg::WR_INSERT;
            state_next  = S_DONE;
          end
        end else if (st.match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DONE;
        end else if (st.probe_last) begin
          if (st.grow_ok) begin
            cmd.i_zero = 1'b1;
            state_next = S_GCLR;
          end else begin
            cmd.set_full = 1'b1;
            state_next   = S_DONE;
          end
        end else begin
          cmd.pos_next = 1'b1;
          state_next   = S_RD;
        end
      end
      S_GCLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = lpga_pkg::WR_CLR_NEW;
        if (st.clr_last) begin
          cmd.i_zero = 1'b1;
          state_next = S_GRD;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_GRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        state_next  = S_GCHK;
      end
      S_GCHK: begin
        if (st.used) begin
          cmd.mv_latch = 1'b1;
          state_next   = S_MRD;
        end else if (st.scan_last) begin
          cmd.grow_end = 1'b1;
          state_next   = S_RD;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_GRD;
        end
      end
      S_MRD: begin
        cmd.rd_en   = 1'b1;
        cmd.use_new = 1'b1;
        state_next  = S_MCHK;
      end
      S_MCHK: begin
        cmd.use_new = 1'b1;
        if (!st.used) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_kind = lpga_pkg::WR_MOVE;
          if (st.scan_last) begin
            cmd.grow_end = 1'b1;
            state_next   = S_RD;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_GRD;
          end
        end else begin
          cmd.pos_next = 1'b1;
          state_next   = S_MRD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/lpga_dp.sv
`default_nettype none
module lpga_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lpga_pkg::ID_W-1:0]   in_id,
  input  wire lpga_pkg::cmd_t              cmd,
  output lpga_pkg::stat_t                  st,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lpga_pkg::OUT_W-1:0]       out_data
);

  localparam int SW = lpga_pkg::SLOT_W;
  localparam int KB = lpga_pkg::KEY_BITS;
  localparam int CW = lpga_pkg::ORD_W;
  localparam int GW = lpga_pkg::ORD_W + 3;

  lpga_pkg::entry_t mem [lpga_pkg::DEPTH];
  lpga_pkg::entry_t rdata;
  lpga_pkg::entry_t wdata;
  logic [lpga_pkg::ADDR_W-1:0] rd_addr, wr_addr;

  logic [KB-1:0]              key;
  logic [SW-1:0]              pos;
  logic [SW-1:0]              n;
  logic [SW-1:0]              i;
  logic                       bank;
  logic [lpga_pkg::LOG_W-1:0] size_log;
  logic [CW-1:0]              count;
  logic [KB-1:0]              mv_key;
  logic [CW-1:0]              mv_order;
  logic                       grew;
  logic [CW-1:0]              res_order;
  logic                       res_new;
  logic                       res_full;

  logic [lpga_pkg::SIZE_W-1:0] size;
  logic [SW-1:0]               mask, new_mask, cur_mask;
  logic [CW:0]                 next_cnt;
  logic                        grow_cond;

  assign size     = lpga_pkg::SIZE_W'(1) << size_log;
  assign mask     = SW'(size - lpga_pkg::SIZE_W'(1));
  assign new_mask = {mask[SW-2:0], 1'b1};
  assign cur_mask = cmd.use_new ? new_mask : mask;
  assign next_cnt = {1'b0, count} + (CW+1)'(1);

  // Grow when (count + 1) * 4 >= (size - 1) * 3 and the size may still double.
  assign grow_cond = ({next_cnt, 2'b00} >= GW'(GW'(mask) * GW'(3)))
                     && (size_log < lpga_pkg::LOG_W'(SW));

  assign st.used       = rdata.used;
  assign st.match      = (rdata.key == key);
  assign st.probe_last = (n == mask);
  assign st.grow_ok    = grow_cond && !grew;
  assign st.clr_last   = (i == new_mask);
  assign st.scan_last  = (i == mask);
  assign st.init_last  = (i == SW'(lpga_pkg::INITIAL_SLOTS - 1));
  assign st.out_free   = !out_valid || out_ready;

  always_comb begin
    if (cmd.rd_scan) begin
      rd_addr = {bank, i};
    end else begin
      rd_addr = {bank ^ cmd.use_new, pos};
    end
  end

  always_comb begin
    wdata = '0;
    unique case (cmd.wr_kind)
      lpga_pkg::WR_CLR_INIT: begin
        wr_addr = {1'b0, i};
      end
      lpga_pkg::WR_CLR_NEW: begin
        wr_addr = {~bank, i};
      end
      lpga_pkg::WR_MOVE: begin
        wr_addr     = {~bank, pos};
        wdata.used  = 1'b1;
        wdata.order = mv_order;
        wdata.key   = mv_key;
      end
      lpga_pkg::WR_INSERT: begin
        wr_addr     = {bank, pos};
        wdata.used  = 1'b1;
        wdata.order = next_cnt[CW-1:0];
        wdata.key   = key;
      end
      default: begin
        wr_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Probe and scan state.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= in_id[KB-1:0];
      pos <= in_id[SW-1:0] & mask;
      n   <= '0;
    end else if (cmd.grow_end) begin
      pos <= key[SW-1:0] & new_mask;
      n   <= '0;
    end else if (cmd.mv_latch) begin
      pos      <= rdata.key[SW-1:0] & new_mask;
      mv_key   <= rdata.key;
      mv_order <= rdata.order;
    end else if (cmd.pos_next) begin
      pos <= (pos + SW'(1)) & cur_mask;
      n   <= n + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else if (cmd.i_zero) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= 1'b0;
      size_log <= lpga_pkg::LOG_W'(lpga_pkg::INIT_LOG);
      count    <= '0;
      grew     <= 1'b0;
    end else begin
      if (cmd.grow_end) begin
        bank     <= ~bank;
        size_log <= size_log + lpga_pkg::LOG_W'(1);
        grew     <= 1'b1;
      end else if (cmd.start) begin
        grew <= 1'b0;
      end
      if (cmd.wr_en && cmd.wr_kind == lpga_pkg::WR_INSERT) begin
        count <= next_cnt[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_order <= '0;
      res_new   <= 1'b0;
      res_full  <= 1'b0;
    end else if (cmd.wr_en && cmd.wr_kind == lpga_pkg::WR_INSERT) begin
      res_order <= next_cnt[CW-1:0];
      res_new   <= 1'b1;
    end else if (cmd.set_hit) begin
      res_order <= rdata.order;
    end else if (cmd.set_full) begin
      res_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'b000, size, res_full, grew, res_new, res_order};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/linear_probe_get_or_add.sv
`default_nettype none
// Each item is probed slot by slot from acceptance to result, each probe being a read
// followed by a compare. A new item is accepted only once the last result is loaded.
// Doubling the table first clears the new bank, then scans every old slot and reprobes
// each live entry into it; a stalled result holds off the next item.
// Reset is synchronous: after it, the first bank's INITIAL_SLOTS used marks are
// cleared before the first item is accepted.
module linear_probe_get_or_add (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // function_id[31:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // child_index[8:0], was_new[9], grew[10],
                                      // full_res[11], table_size[20:12], zero[23:21]
);

  lpga_pkg::cmd_t  cmd;
  lpga_pkg::stat_t st;

  lpga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lpga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_id     (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

FILE: verif/linear_probe_get_or_add_tb.sv
`timescale 1ns / 100ps

module linear_probe_get_or_add_tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASE_ITEMS  = 480;

  typedef enum int {PROBE_FREE, PROBE_HIT, PROBE_NONE} probe_t;

  // Same layout as m_tdata, lowest field last.
  typedef struct packed {
    logic [2:0]                  pad;
    logic [lpga_pkg::SIZE_W-1:0] table_size;
    logic                        full_res;
    logic                        grew;
    logic                        was_new;
    logic [lpga_pkg::ORD_W-1:0]  child_index;
  } reply_t;

  class table_scoreboard_t;
    logic [lpga_pkg::KEY_BITS-1:0] slot_key [lpga_pkg::DEPTH];
    logic [lpga_pkg::ORD_W-1:0]    slot_order [lpga_pkg::DEPTH];
    bit                            slot_used [lpga_pkg::DEPTH];
    int                            bank;
    int                            size_log;
    int                            entry_count;
    reply_t                        expected_replies [$];
    int                            errors;
    int                            requests;
    int                            replies;
    int                            inserts;
    int                            hits;
    int                            growths;
    int                            refusals;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      bank        = 0;
      size_log    = lpga_pkg::INIT_LOG;
      entry_count = 0;
      errors      = 0;
      requests    = 0;
      replies     = 0;
      inserts     = 0;
      hits        = 0;
      growths     = 0;
      refusals    = 0;
    endfunction

    function probe_t probe_table(int b, int size, logic [lpga_pkg::KEY_BITS-1:0] key,
                                 output int pos);
      int start;
      int idx;
      start = int'(key & lpga_pkg::KEY_BITS'(size - 1));
      pos = 0;
      for (int n = 0; n < size; n++) begin
        idx = b * lpga_pkg::MAX_SLOTS + ((start + n) & (size - 1));
        if (!slot_used[idx]) begin
          pos = idx;
          return PROBE_FREE;
        end
        if (slot_key[idx] == key) begin
          pos = idx;
          return PROBE_HIT;
        end
      end
      return PROBE_NONE;
    endfunction

    // Doubles the table into the other bank, carrying every live entry over.
    function void rehash_grow();
      int old_bank;
      int new_bank;
      int old_size;
      int src;
      int pos;
      old_bank = bank;
      new_bank = 1 - bank;
      old_size = 1 << size_log;
      for (int i = 0; i < lpga_pkg::MAX_SLOTS; i++) begin
        slot_used[new_bank * lpga_pkg::MAX_SLOTS + i] = 1'b0;
      end
      for (int i = 0; i < old_size; i++) begin
        src = old_bank * lpga_pkg::MAX_SLOTS + i;
        if (slot_used[src] &&
            probe_table(new_bank, 2 * old_size, slot_key[src], pos) == PROBE_FREE) begin
          slot_used[pos]  = 1'b1;
          slot_key[pos]   = slot_key[src];
          slot_order[pos] = slot_order[src];
        end
      end
      bank = new_bank;
      size_log++;
    endfunction

    function void note_request(logic [lpga_pkg::ID_W-1:0] id);
      logic [lpga_pkg::KEY_BITS-1:0] key;
      int                            size;
      int                            pos;
      int                            next;
      probe_t                        found;
      reply_t                        want;
      key   = id[lpga_pkg::KEY_BITS-1:0];
      size  = 1 << size_log;
      want  = '0;
      requests++;
      found = probe_table(bank, size, key, pos);
      if (found == PROBE_HIT) begin
        want.child_index = slot_order[pos];
        hits++;
      end else begin
        next = entry_count + 1;
        if (next * 4 >= (size - 1) * 3 && size * 2 <= lpga_pkg::MAX_SLOTS) begin
          rehash_grow();
          want.grew = 1'b1;
          growths++;
          size  = 1 << size_log;
          found = probe_table(bank, size, key, pos);
        end
        if (found == PROBE_FREE) begin
          entry_count      = next;
          slot_used[pos]   = 1'b1;
          slot_key[pos]    = key;
          slot_order[pos]  = lpga_pkg::ORD_W'(next);
          want.child_index = lpga_pkg::ORD_W'(next);
          want.was_new     = 1'b1;
          inserts++;
        end else begin
          want.full_res = 1'b1;
          refusals++;
        end
      end
      want.table_size = lpga_pkg::SIZE_W'(size);
      expected_replies.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [lpga_pkg::OUT_W-1:0] data);
      reply_t got;
      reply_t want;
      got = reply_t'(data);
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result %h with no request outstanding", $time, data);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      replies++;
      compare_field("child_index", int'(want.child_index), int'(got.child_index));
      compare_field("was_new", int'(want.was_new), int'(got.was_new));
      compare_field("grew", int'(want.grew), int'(got.grew));
      compare_field("full_res", int'(want.full_res), int'(got.full_res));
      compare_field("table_size", int'(want.table_size), int'(got.table_size));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [lpga_pkg::ID_W-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [lpga_pkg::OUT_W-1:0] m_tdata;

  table_scoreboard_t          sb;
  logic [lpga_pkg::ID_W-1:0]  sent_ids [$];
  int                         sender_idle;
  int                         recv_stall;
  int                         holds_asked;
  int                         holds_done;

  linear_probe_get_or_add DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_reply(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
    end
  end

  // Receiver: random stalls, plus a long hold whenever one has been asked for.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        holds_done++;
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #(400_000_000);
    $display("Timeout with %0d results outstanding", sb.expected_replies.size());
    $display("Regression FAIL");
    $finish;
  end

  // Leaves s_tvalid high after acceptance so back-to-back items need no extra step.
  task automatic send_request(input logic [lpga_pkg::ID_W-1:0] id);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_ids.push_back(id);
  endtask

  // Mostly random ids; a quarter are crowded onto a few start slots to build long probe runs.
  function automatic logic [lpga_pkg::ID_W-1:0] fresh_id();
    logic [lpga_pkg::ID_W-1:0] id;
    id = $urandom;
    if ($urandom_range(3) == 0) id[5:0] = 6'($urandom_range(3));
    return id;
  endfunction

  task automatic random_requests(input int count, input int idle_pct, input int stall_pct);
    logic [lpga_pkg::ID_W-1:0] id;
    sender_idle = idle_pct;
    recv_stall  = stall_pct;
    repeat (count) begin
      if (sent_ids.size() != 0 && $urandom_range(99) < 78)
        id = sent_ids[$urandom_range(sent_ids.size() - 1)];
      else
        id = fresh_id();
      send_request(id);
    end
  endtask

  initial begin
    logic [lpga_pkg::ID_W-1:0] opening [];
    opening = '{
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0004, 32'hFFFF_FFFF,
      32'h0000_0008, 32'h0000_0010, 32'h0000_0018, 32'h0000_0007, 32'h0000_000F,
      32'h0000_001F, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h0000_0004, 32'h0000_001F, 32'h0000_0000, 32'h1234_5678
    };
    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    sender_idle = 0;
    recv_stall  = 0;
    holds_asked = 0;
    holds_done  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Collisions on slot zero, wrap-around at the top slot, and the first three growths.
    sender_idle = 13;
    recv_stall  = 13;
    foreach (opening[i]) send_request(opening[i]);

    holds_asked = 1;
    random_requests(PHASE_ITEMS, 0, 0);
    random_requests(PHASE_ITEMS, 49, 0);
    random_requests(PHASE_ITEMS, 0, 49);
    random_requests(PHASE_ITEMS, 13, 13);
    s_tvalid <= 1'b0;

    while (sb.expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d inserts, %0d hits, %0d growths, %0d refused as full.",
             sb.requests, sb.inserts, sb.hits, sb.growths, sb.refusals);
    $display("Table ended at %0d slots holding %0d entries; %0d results checked.",
             1 << sb.size_log, sb.entry_count, sb.replies);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
